>>> rtl/mrpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_pkg: shared constants for the Miller-Rabin prime test
// Holds the number width, the trial prime list and the fixed witness bases.
// ----------------------------------------------------------------------------
package mrpt_pkg;

   // Width of the number under test; the upper port bits are ignored.
   localparam int NUMBER_WIDTH      = 64;
   // Number of fixed witness bases tried, and of trial primes divided out.
   localparam int BASE_COUNT        = 7;
   localparam int TRIAL_PRIME_COUNT = 11;

   localparam int COUNT_WIDTH = $clog2(NUMBER_WIDTH);
   localparam int INDEX_WIDTH = $clog2(BASE_COUNT + 1);

   typedef logic [NUMBER_WIDTH-1:0] number_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [INDEX_WIDTH-1:0]  index_type;
   typedef logic [4:0]              residue_type;

   // Small primes for the trial division pass.
   localparam logic [4:0] TRIAL_TAB [11] = '{
      5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29, 5'd31
   };

   // Witness bases, in the order they are tried.
   localparam logic [5:0] BASE_TAB [12] = '{
      6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
   };

endpackage

>>> rtl/miller_rabin_prime_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_prime_test: fixed-base Miller-Rabin primality test
// Trial division by small primes, then modular exponentiation per base.
// ----------------------------------------------------------------------------
// One number is tested at a time and req_stall stays high until the verdict
// has been moved to the output register. Trial division runs all small primes
// in parallel lanes, one bit a cycle; splitting n-1 strips its trailing zeros
// one at a time, and every modular product goes through a single shared
// modular adder by shift-and-add: each multiplier bit, top bit first, takes a
// doubling step plus an add step when the bit is set. A 64-bit number that
// survives trial division needs up to 126 products per base. A full-width
// prime goes through all seven bases, a composite usually fails at the first
// base, and numbers caught by trial division finish without any modular
// exponentiation.
module miller_rabin_prime_test
   import mrpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_prime
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TRIAL   = 4'd1;
   localparam logic [3:0] S_TEVAL   = 4'd2;
   localparam logic [3:0] S_SPLIT   = 4'd3;
   localparam logic [3:0] S_BASE    = 4'd4;
   localparam logic [3:0] S_POW     = 4'd5;
   localparam logic [3:0] S_MUL_DBL = 4'd6;
   localparam logic [3:0] S_MUL_ADD = 4'd7;
   localparam logic [3:0] S_CHECK   = 4'd8;
   localparam logic [3:0] S_SQ      = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   localparam logic [1:0] MUL_XB = 2'd0;
   localparam logic [1:0] MUL_BB = 2'd1;
   localparam logic [1:0] MUL_XX = 2'd2;

   localparam count_type LAST_BIT = count_type'(NUMBER_WIDTH - 1);
   localparam number_type ONE = number_type'(1);

   logic [3:0]  state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   number_type  n_ff, n_in;
   number_type  nm1_ff, nm1_in;
   number_type  d_ff, d_in;
   number_type  x_ff, x_in;
   number_type  b_ff, b_in;
   number_type  e_ff, e_in;
   number_type  r_ff, r_in;
   number_type  ma_ff, ma_in;
   number_type  mb_ff, mb_in;
   count_type   cnt_ff, cnt_in;
   count_type   s_ff, s_in;
   count_type   sq_ff, sq_in;
   index_type   idx_ff, idx_in;
   logic        verdict_ff, verdict_in;
   residue_type rem_ff [TRIAL_PRIME_COUNT];
   residue_type rem_in [TRIAL_PRIME_COUNT];
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_is_prime_ff, rsp_is_prime_in;

   // Shared modular adder: (r + addend) mod n, both operands below n.
   number_type              add_b;
   logic [NUMBER_WIDTH:0]   add_sum;
   logic [NUMBER_WIDTH:0]   add_diff;
   number_type              add_res;

   assign add_b    = (state_ff == S_MUL_ADD) ? ma_ff : r_ff;
   assign add_sum  = {1'b0, r_ff} + {1'b0, add_b};
   assign add_diff = add_sum - {1'b0, n_ff};
   assign add_res  = (add_sum >= {1'b0, n_ff}) ? add_diff[NUMBER_WIDTH-1:0]
                                               : add_sum[NUMBER_WIDTH-1:0];

   // Trial lanes: fold one more bit of n into each residue.
   logic [5:0]  rem_wide [TRIAL_PRIME_COUNT];
   residue_type rem_step [TRIAL_PRIME_COUNT];
   logic        any_equal;
   logic        any_divides;
   logic [5:0]  base_value;

   always_comb begin
      any_equal   = 1'b0;
      any_divides = 1'b0;
      for (int k = 0; k < TRIAL_PRIME_COUNT; k++) begin
         rem_wide[k] = {rem_ff[k], mb_ff[NUMBER_WIDTH-1]};
         rem_step[k] = (rem_wide[k] >= {1'b0, TRIAL_TAB[k]})
                       ? residue_type'(rem_wide[k] - {1'b0, TRIAL_TAB[k]})
                       : rem_wide[k][4:0];
         if (n_ff == number_type'(TRIAL_TAB[k])) begin
            any_equal = 1'b1;
         end
         if (rem_ff[k] == residue_type'(0)) begin
            any_divides = 1'b1;
         end
      end
   end

   assign base_value = BASE_TAB[idx_ff];

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      n_in            = n_ff;
      nm1_in          = nm1_ff;
      d_in            = d_ff;
      x_in            = x_ff;
      b_in            = b_ff;
      e_in            = e_ff;
      r_in            = r_ff;
      ma_in           = ma_ff;
      mb_in           = mb_ff;
      cnt_in          = cnt_ff;
      s_in            = s_ff;
      sq_in           = sq_ff;
      idx_in          = idx_ff;
      verdict_in      = verdict_ff;
      rem_in          = rem_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_is_prime_in = rsp_is_prime_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               n_in   = req_number[NUMBER_WIDTH-1:0];
               mb_in  = req_number[NUMBER_WIDTH-1:0];
               cnt_in = '0;
               for (int k = 0; k < TRIAL_PRIME_COUNT; k++) begin
                  rem_in[k] = '0;
               end
               state_in = S_TRIAL;
            end
         end

         S_TRIAL: begin
            rem_in = rem_step;
            mb_in  = {mb_ff[NUMBER_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + count_type'(1);
            if (cnt_ff == LAST_BIT) begin
               state_in = S_TEVAL;
            end
         end

         S_TEVAL: begin
            nm1_in = n_ff - ONE;
            d_in   = n_ff - ONE;
            s_in   = '0;
            if (n_ff < number_type'(2)) begin
               verdict_in = 1'b0;
               state_in   = S_DONE;
            end else if (any_equal) begin
               verdict_in = 1'b1;
               state_in   = S_DONE;
            end else if (any_divides) begin
               verdict_in = 1'b0;
               state_in   = S_DONE;
            end else begin
               state_in = S_SPLIT;
            end
         end

         // Strip the trailing zeros of n-1, one a cycle.
         S_SPLIT: begin
            if (!d_ff[0] && (d_ff != '0)) begin
               d_in = {1'b0, d_ff[NUMBER_WIDTH-1:1]};
               s_in = s_ff + count_type'(1);
            end else begin
               idx_in   = '0;
               state_in = S_BASE;
            end
         end

         S_BASE: begin
            if (idx_ff == index_type'(BASE_COUNT)) begin
               verdict_in = 1'b1;
               state_in   = S_DONE;
            end else if (number_type'(base_value) >= n_ff) begin
               idx_in = idx_ff + index_type'(1);
            end else begin
               x_in     = ONE;
               b_in     = number_type'(base_value);
               e_in     = d_ff;
               state_in = S_POW;
            end
         end

         // Square-and-multiply over the exponent bits, low bit first.
         S_POW: begin
            r_in   = '0;
            cnt_in = '0;
            if (e_ff == '0) begin
               state_in = S_CHECK;
            end else if (e_ff[0]) begin
               op_in    = MUL_XB;
               ma_in    = x_ff;
               mb_in    = b_ff;
               state_in = S_MUL_DBL;
            end else begin
               op_in    = MUL_BB;
               ma_in    = b_ff;
               mb_in    = b_ff;
               state_in = S_MUL_DBL;
            end
         end

         S_MUL_DBL, S_MUL_ADD: begin
            r_in = add_res;
            if ((state_ff == S_MUL_DBL) && mb_ff[NUMBER_WIDTH-1]) begin
               state_in = S_MUL_ADD;
            end else begin
               mb_in    = {mb_ff[NUMBER_WIDTH-2:0], 1'b0};
               cnt_in   = cnt_ff + count_type'(1);
               state_in = S_MUL_DBL;
               if (cnt_ff == LAST_BIT) begin
                  // Product complete: hand it to its destination.
                  unique case (op_ff)
                     MUL_XB: begin
                        x_in   = add_res;
                        op_in  = MUL_BB;
                        r_in   = '0;
                        cnt_in = '0;
                        ma_in  = b_ff;
                        mb_in  = b_ff;
                     end
                     MUL_BB: begin
                        b_in     = add_res;
                        e_in     = {1'b0, e_ff[NUMBER_WIDTH-1:1]};
                        state_in = S_POW;
                     end
                     default: begin
                        x_in  = add_res;
                        sq_in = sq_ff + count_type'(1);
                        if (add_res == nm1_ff) begin
                           idx_in   = idx_ff + index_type'(1);
                           state_in = S_BASE;
                        end else begin
                           state_in = S_SQ;
                        end
                     end
                  endcase
               end
            end
         end

         S_CHECK: begin
            if ((x_ff == ONE) || (x_ff == nm1_ff)) begin
               idx_in   = idx_ff + index_type'(1);
               state_in = S_BASE;
            end else begin
               sq_in    = count_type'(1);
               state_in = S_SQ;
            end
         end

         // Repeated squaring looking for n-1.
         S_SQ: begin
            if (sq_ff >= s_ff) begin
               verdict_in = 1'b0;
               state_in   = S_DONE;
            end else begin
               op_in    = MUL_XX;
               r_in     = '0;
               cnt_in   = '0;
               ma_in    = x_ff;
               mb_in    = x_ff;
               state_in = S_MUL_DBL;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = verdict_ff;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      n_ff            <= n_in;
      nm1_ff          <= nm1_in;
      d_ff            <= d_in;
      x_ff            <= x_in;
      b_ff            <= b_in;
      e_ff            <= e_in;
      r_ff            <= r_in;
      ma_ff           <= ma_in;
      mb_ff           <= mb_in;
      cnt_ff          <= cnt_in;
      s_ff            <= s_in;
      sq_ff           <= sq_in;
      idx_ff          <= idx_in;
      verdict_ff      <= verdict_in;
      rem_ff          <= rem_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

endmodule

>>> sim/tb_miller_rabin_prime_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_prime_test: self-checking bench for the prime test block
// A queue of numbers feeds a clocked driver, and a clocked monitor compares
// each verdict with a fixed-base primality predictor at 128-bit precision.
// Both sides idle at random. The receiver holds off once for a long stretch,
// and the sender drains completely between the directed and random phases.
// ----------------------------------------------------------------------------
module tb_miller_rabin_prime_test;
   import mrpt_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_number;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_is_prime;

   logic [63:0] pending_numbers [$];
   bit          expected_verdicts [$];
   int          mismatch_count;
   int          numbers_accepted;
   int          verdicts_checked;
   int          primes_seen;
   int          send_gap;
   int          hold_cycles;
   bit          long_hold_done;

   miller_rabin_prime_test dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime)
   );

   // 2 ns clock.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Exact modular product through a double-width intermediate.
   function automatic number_type mod_product(number_type a, number_type b, number_type m);
      logic [127:0] wide;
      begin
         wide = {64'd0, a} * {64'd0, b};
         return number_type'(wide % {64'd0, m});
      end
   endfunction

   function automatic number_type mod_power(number_type a, number_type e, number_type m);
      number_type acc;
      number_type sq;
      begin
         acc = 1 % m;
         sq  = a % m;
         while (e != 0) begin
            if (e[0])
               acc = mod_product(acc, sq, m);
            sq = mod_product(sq, sq, m);
            e  = e >> 1;
         end
         return acc;
      end
   endfunction

   // Verdict of the fixed-base test on the low NUMBER_WIDTH bits.
   function automatic bit passes_prime_test(logic [63:0] raw);
      number_type n;
      number_type odd_part;
      number_type x;
      int         twos;
      bit         witness_ok;
      begin
         n = raw[NUMBER_WIDTH-1:0];
         if (n < 2)
            return 1'b0;
         for (int i = 0; i < TRIAL_PRIME_COUNT; i++) begin
            if (n == TRIAL_TAB[i])
               return 1'b1;
            if (n % TRIAL_TAB[i] == 0)
               return 1'b0;
         end
         odd_part = n - 1;
         twos     = 0;
         while (odd_part != 0 && !odd_part[0]) begin
            odd_part = odd_part >> 1;
            twos++;
         end
         for (int i = 0; i < BASE_COUNT; i++) begin
            // A base not below the number is skipped.
            if (BASE_TAB[i] >= n)
               continue;
            x = mod_power(number_type'(BASE_TAB[i]), odd_part, n);
            if (x == 1 || x == n - 1)
               continue;
            witness_ok = 1'b0;
            for (int r = 1; r < twos; r++) begin
               x = mod_product(x, x, n);
               if (x == n - 1) begin
                  witness_ok = 1'b1;
                  break;
               end
            end
            if (!witness_ok)
               return 1'b0;
         end
         return 1'b1;
      end
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int draw_gap();
      int pick;
      begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            return 0;
         else if (pick < 90)
            return $urandom_range(1, 3);
         else
            return $urandom_range(20, 60);
      end
   endfunction

   // Driver: records each accepted beat, then offers the next number.
   always @(posedge clock) begin
      logic        next_valid;
      logic [63:0] next_number;
      if (reset) begin
         req_valid  <= 1'b0;
         req_number <= '0;
         send_gap   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_verdicts.push_back(passes_prime_test(req_number));
            numbers_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            next_valid  = 1'b0;
            next_number = {$urandom, $urandom};
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_numbers.size() != 0) begin
               next_valid  = 1'b1;
               next_number = pending_numbers.pop_front();
               send_gap    = draw_gap();
            end
            req_valid  <= next_valid;
            req_number <= next_number;
         end
      end
   end

   // Receiver stall: one long hold-off right after reset, so that a finished
   // verdict waits in the output while the next number completes behind it;
   // random otherwise.
   always @(posedge clock) begin
      logic next_stall;
      if (reset) begin
         rsp_stall      <= 1'b0;
         hold_cycles    = 0;
         long_hold_done = 1'b0;
      end else begin
         if (hold_cycles > 0) begin
            hold_cycles--;
            next_stall = 1'b1;
         end else if (!long_hold_done && verdicts_checked == 0) begin
            long_hold_done = 1'b1;
            hold_cycles    = 400;
            next_stall     = 1'b1;
         end else if ($urandom_range(0, 99) < 70) begin
            next_stall = 1'b0;
         end else begin
            next_stall = 1'b1;
            hold_cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : 0;
         end
         rsp_stall <= next_stall;
      end
   end

   // Monitor: each verdict beat against the oldest expectation.
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected verdict beat: is_prime=%0b", rsp_is_prime);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_is_prime !== want) begin
               $error("is_prime: expected %0b, actual %0b", want, rsp_is_prime);
               mismatch_count++;
            end
            if (want)
               primes_seen++;
            verdicts_checked++;
         end
      end
   end

   // Sampled between edges, once the clocked processes have settled.
   task automatic wait_for_drain();
      begin
         do
            @(negedge clock);
         while (pending_numbers.size() != 0 || req_valid || expected_verdicts.size() != 0);
      end
   endtask

   // Stimulus: directed numbers, a full drain, then the random mix.
   initial begin
      logic [63:0] value;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      pending_numbers.push_back(64'd0);
      pending_numbers.push_back(64'd1);
      pending_numbers.push_back(64'd2);
      pending_numbers.push_back(64'd31);
      pending_numbers.push_back(64'd37);
      pending_numbers.push_back(64'd41);
      pending_numbers.push_back(64'd961);          // square of the last trial prime
      pending_numbers.push_back(64'd1369);         // square of a prime above the trial list
      pending_numbers.push_back(64'd3215031751);   // fools the first four bases
      pending_numbers.push_back(64'd2305843009213693951);
      pending_numbers.push_back(64'hFFFF_FFFF_FFFF_FFC5); // largest 64-bit prime
      pending_numbers.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      pending_numbers.push_back(64'h8000_0000_0000_0000);
      pending_numbers.push_back(64'd1099511627777);       // n-1 has forty trailing zeros
      pending_numbers.push_back(64'd4294967311);
      wait_for_drain();

      for (int i = 0; i < 90; i++) begin
         case ($urandom_range(0, 3))
            0: value = {$urandom, $urandom};
            1: value = 64'($urandom_range(0, 65535));
            2: value = {$urandom, $urandom} | 64'd1;
            default: value = (64'($urandom) << $urandom_range(0, 31)) + 1;
         endcase
         pending_numbers.push_back(value);
      end
      wait_for_drain();
      repeat (300) @(posedge clock);

      $display("Tested %0d numbers, %0d verdicts checked, %0d of them prime.",
               numbers_accepted, verdicts_checked, primes_seen);
      if (mismatch_count == 0 && expected_verdicts.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Overall time limit.
   initial begin
      #400_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
